// ===== rtl/core/nrp_pkg.sv =====
// ----------------------------------------------------------------------------
// nrp_pkg: shared types and constants of the nested region profiler
// Request and report payloads, request codes and sequencer states.
// ----------------------------------------------------------------------------
package nrp_pkg;

	localparam int REGIONS = 16;
	localparam int TOT_W = 40;
	localparam logic [15:0] GAIN_RESET = 16'd52429;

	typedef enum logic [1:0] {
		REQ_BEGIN = 2'd0,
		REQ_END   = 2'd1,
		REQ_FRAME = 2'd2,
		REQ_NONE  = 2'd3
	} req_code_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [3:0]  region_id;
		logic [31:0] timestamp;
		logic [19:0] elapsed_time;
	} req_t;

	typedef struct packed {
		logic [3:0]         out_region;
		logic signed [15:0] avg_percent;
		logic [14:0]        min_percent;
		logic signed [15:0] max_percent;
		logic [15:0]        call_count;
		logic [4:0]         nesting_depth;
		logic               unbalanced;
		logic               last_line;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIND,
		ST_SCAN,
		ST_UPD,
		ST_FMUL,
		ST_FRATIO,
		ST_PREP,
		ST_DIV,
		ST_PFIN,
		ST_HIST,
		ST_BMUL,
		ST_BWR,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		SEL_AVG,
		SEL_MIN,
		SEL_MAX
	} hist_sel_t;

	// round half up of (h*65536 + prod) / 65536, saturated to 16 bits
	function automatic logic signed [15:0] blend(input logic signed [15:0] h,
		input logic signed [38:0] prod);
		logic signed [39:0] s;
		logic signed [39:0] q;
		begin
			s = (40'(h) <<< 16) + 40'(prod) + 40'sd32768;
			q = s >>> 16;
			if (q > 40'sd32767) begin
				blend = 16'sh7fff;
			end else if (q < -40'sd32768) begin
				blend = 16'sh8000;
			end else begin
				blend = q[15:0];
			end
		end
	endfunction

endpackage

// ===== rtl/core/nested_region_profiler_top.sv =====
// ----------------------------------------------------------------------------
// nested_region_profiler_top: hierarchical frame profiler with smoothing
// Slot table of nested regions, per-region smoothed self-time history.
// ----------------------------------------------------------------------------
//  channel | signals                      | width      | direction
//  req     | req_valid, req_ready, req    | nrp_pkg::req_t | in
//  rsp     | rsp_valid, rsp_ready, rsp    | nrp_pkg::rsp_t | out
//  cfg     | cfg_valid, cfg_ready, cfg_data | 16       | in
//
//  begin searches the slot table; end searches it, then scans the open regions.
//  frame end runs per slot an overflow check, a 17-step restoring divider and,
//  for a region with history, three blends through one shared 21x18 multiplier.
//  req_ready is high only in idle; a stalled rsp channel holds the sequencer at
//  the waiting line. reset clears slot count, frame start and history valid
//  bits, and loads gain with GAIN_RESET.
module nested_region_profiler_top #(
	parameter int SLOTS = 16,
	parameter int TIME_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  nrp_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output nrp_pkg::rsp_t  rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [15:0]    cfg_data
);

	localparam int SIDX = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int SW = ((TIME_BITS > nrp_pkg::TOT_W) ? TIME_BITS : nrp_pkg::TOT_W) + 1;
	localparam int RW = (TIME_BITS + 17 > 56) ? TIME_BITS + 17 : 56;
	localparam logic [SW-1:0] TOT_MAX = SW'({nrp_pkg::TOT_W{1'b1}});

	nrp_pkg::state_t state_q, state_d;

	// slot table
	logic [3:0]                    slot_region_q [SLOTS];
	logic signed [7:0]             slot_open_q   [SLOTS];
	logic [15:0]                   slot_calls_q  [SLOTS];
	logic [TIME_BITS-1:0]          slot_start_q  [SLOTS];
	logic [nrp_pkg::TOT_W-1:0]     slot_total_q  [SLOTS];
	logic [nrp_pkg::TOT_W-1:0]     slot_child_q  [SLOTS];
	logic [4:0]                    slot_depth_q  [SLOTS];

	// history
	logic                          hist_valid_q [nrp_pkg::REGIONS];
	logic signed [15:0]            hist_avg_q   [nrp_pkg::REGIONS];
	logic signed [15:0]            hist_min_q   [nrp_pkg::REGIONS];
	logic signed [15:0]            hist_max_q   [nrp_pkg::REGIONS];

	logic [CW-1:0]         used_q;
	logic [TIME_BITS-1:0]  frame_start_q;
	logic [15:0]           gain_q;

	logic [1:0]            type_q;
	logic [3:0]            id_q;
	logic [TIME_BITS-1:0]  ts_q;
	logic [19:0]           elapsed_q;

	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         count_q;
	logic [SIDX-1:0]       hit_q;
	logic [SIDX-1:0]       par_q;
	logic                  parv_q;
	logic [TIME_BITS-1:0]  par_start_q;

	logic [TIME_BITS-1:0]  len_q;
	logic [16:0]           ratio_q;
	logic signed [38:0]    prod_q;
	logic [RW-1:0]         rem_q;
	logic [RW-1:0]         dsr_q;
	logic [4:0]            k_q;
	logic [16:0]           quo_q;
	logic                  ovf_q;
	logic                  neg_q;
	logic signed [15:0]    p_q;
	logic [3:0]            rg_q;
	nrp_pkg::hist_sel_t    sel_q;

	logic                  rsp_valid_q;
	nrp_pkg::rsp_t         rsp_q;

	// combinational helpers
	logic [SIDX-1:0]       idx;
	logic                  in_range;
	logic                  match;
	logic                  is_last;
	logic                  can_load;
	logic                  div_ge;
	logic                  neg;
	logic [nrp_pkg::TOT_W-1:0] mag;
	logic [RW-1:0]         num;
	logic [TIME_BITS-1:0]  dur;
	logic [SW-1:0]         tot_sum;
	logic [SW-1:0]         chd_sum;
	logic [7:0]            count8;
	logic signed [15:0]    h_cur;
	logic signed [16:0]    diff;
	logic signed [20:0]    mul_a;
	logic signed [17:0]    mul_b;
	logic signed [38:0]    mul_p;
	logic signed [15:0]    bl;
	logic signed [15:0]    min_pick;
	logic [19:0]           ratio_raw;

	assign idx      = cnt_q[SIDX-1:0];
	assign in_range = cnt_q < used_q;
	assign match    = slot_region_q[idx] == id_q;
	assign is_last  = (cnt_q + CW'(1)) == used_q;
	assign can_load = !rsp_valid_q || rsp_ready;
	assign div_ge   = rem_q >= dsr_q;

	assign neg = slot_child_q[idx] > slot_total_q[idx];
	assign mag = neg ? slot_child_q[idx] - slot_total_q[idx]
	                 : slot_total_q[idx] - slot_child_q[idx];
	// mag * 25600 as shifted adds, plus half the divisor for rounding
	assign num = (RW'(mag) << 14) + (RW'(mag) << 13) + (RW'(mag) << 10)
	           + RW'(len_q >> 1);

	assign dur     = ts_q - slot_start_q[hit_q];
	assign tot_sum = SW'(slot_total_q[hit_q]) + SW'(dur);
	assign chd_sum = SW'(slot_child_q[par_q]) + SW'(dur);
	assign count8  = 8'(count_q);

	always_comb begin
		unique case (sel_q)
			nrp_pkg::SEL_AVG: h_cur = hist_avg_q[rg_q];
			nrp_pkg::SEL_MIN: h_cur = hist_min_q[rg_q];
			default:          h_cur = hist_max_q[rg_q];
		endcase
	end

	assign diff = $signed({p_q[15], p_q}) - $signed({h_cur[15], h_cur});

	// shared multiplier: ratio product at frame start, blend products after
	always_comb begin
		if (state_q == nrp_pkg::ST_FMUL) begin
			mul_a = $signed({1'b0, elapsed_q});
			mul_b = $signed({2'b00, gain_q});
		end else begin
			mul_a = $signed({{4{diff[16]}}, diff});
			mul_b = $signed({1'b0, ratio_q});
		end
	end

	assign mul_p     = mul_a * mul_b;
	assign bl        = nrp_pkg::blend(h_cur, prod_q);
	assign min_pick  = (p_q < h_cur) ? p_q : bl;
	assign ratio_raw = prod_q[35:16];

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nrp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nrp_pkg::ST_IDLE: begin
				if (req_valid) begin
					unique case (nrp_pkg::req_code_t'(req.req_type))
						nrp_pkg::REQ_BEGIN, nrp_pkg::REQ_END: state_d = nrp_pkg::ST_FIND;
						nrp_pkg::REQ_FRAME: state_d = nrp_pkg::ST_FMUL;
						default: state_d = nrp_pkg::ST_IDLE;
					endcase
				end
			end
			nrp_pkg::ST_FIND: begin
				priority if (!in_range) begin
					state_d = nrp_pkg::ST_IDLE;
				end else if (match) begin
					state_d = (type_q == nrp_pkg::REQ_END) ? nrp_pkg::ST_SCAN
					                                       : nrp_pkg::ST_IDLE;
				end else begin
					state_d = nrp_pkg::ST_FIND;
				end
			end
			nrp_pkg::ST_SCAN: begin
				if (!in_range) begin
					state_d = nrp_pkg::ST_UPD;
				end
			end
			nrp_pkg::ST_UPD:    state_d = nrp_pkg::ST_IDLE;
			nrp_pkg::ST_FMUL: begin
				state_d = (used_q == '0) ? nrp_pkg::ST_IDLE : nrp_pkg::ST_FRATIO;
			end
			nrp_pkg::ST_FRATIO: state_d = nrp_pkg::ST_PREP;
			nrp_pkg::ST_PREP: begin
				state_d = (mag == '0 || len_q == '0) ? nrp_pkg::ST_HIST : nrp_pkg::ST_DIV;
			end
			nrp_pkg::ST_DIV: begin
				if ((k_q == 5'd17 && div_ge) || k_q == 5'd0) begin
					state_d = nrp_pkg::ST_PFIN;
				end
			end
			nrp_pkg::ST_PFIN:   state_d = nrp_pkg::ST_HIST;
			nrp_pkg::ST_HIST: begin
				state_d = hist_valid_q[rg_q] ? nrp_pkg::ST_BMUL : nrp_pkg::ST_EMIT;
			end
			nrp_pkg::ST_BMUL:   state_d = nrp_pkg::ST_BWR;
			nrp_pkg::ST_BWR: begin
				state_d = (sel_q == nrp_pkg::SEL_MAX) ? nrp_pkg::ST_EMIT : nrp_pkg::ST_BMUL;
			end
			nrp_pkg::ST_EMIT: begin
				if (can_load) begin
					state_d = is_last ? nrp_pkg::ST_IDLE : nrp_pkg::ST_PREP;
				end
			end
			default: state_d = nrp_pkg::ST_IDLE;
		endcase
	end

	// control state with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q        <= '0;
			frame_start_q <= '0;
			gain_q        <= nrp_pkg::GAIN_RESET;
			rsp_valid_q   <= 1'b0;
			for (int r = 0; r < nrp_pkg::REGIONS; r++) begin
				hist_valid_q[r] <= 1'b0;
			end
		end else begin
			if (cfg_valid) begin
				gain_q <= cfg_data;
			end
			if (state_q == nrp_pkg::ST_FIND && !in_range && type_q == nrp_pkg::REQ_BEGIN
			    && used_q < CW'(SLOTS)) begin
				used_q <= used_q + CW'(1);
			end
			if (state_q == nrp_pkg::ST_FMUL && used_q == '0) begin
				frame_start_q <= ts_q;
			end
			if (state_q == nrp_pkg::ST_HIST && !hist_valid_q[rg_q]) begin
				hist_valid_q[rg_q] <= 1'b1;
			end
			if (state_q == nrp_pkg::ST_EMIT && can_load) begin
				rsp_valid_q <= 1'b1;
				if (is_last) begin
					used_q        <= '0;
					frame_start_q <= ts_q;
				end
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath and tables
	always_ff @(posedge clk) begin
		unique case (state_q)
			nrp_pkg::ST_IDLE: begin
				type_q    <= req.req_type;
				id_q      <= req.region_id;
				ts_q      <= TIME_BITS'(req.timestamp);
				elapsed_q <= req.elapsed_time;
				cnt_q     <= '0;
			end
			nrp_pkg::ST_FIND: begin
				if (!in_range) begin
					if (type_q == nrp_pkg::REQ_BEGIN && used_q < CW'(SLOTS)) begin
						slot_region_q[used_q[SIDX-1:0]] <= id_q;
						slot_open_q[used_q[SIDX-1:0]]   <= 8'sd1;
						slot_calls_q[used_q[SIDX-1:0]]  <= 16'd1;
						slot_start_q[used_q[SIDX-1:0]]  <= ts_q;
						slot_total_q[used_q[SIDX-1:0]]  <= '0;
						slot_child_q[used_q[SIDX-1:0]]  <= '0;
						slot_depth_q[used_q[SIDX-1:0]]  <= '0;
					end
				end else if (match) begin
					if (type_q == nrp_pkg::REQ_END) begin
						if (slot_open_q[idx] != -8'sd128) begin
							slot_open_q[idx] <= slot_open_q[idx] - 8'sd1;
						end
						hit_q   <= idx;
						cnt_q   <= '0;
						count_q <= '0;
						parv_q  <= 1'b0;
					end else begin
						if (slot_open_q[idx] != 8'sd127) begin
							slot_open_q[idx] <= slot_open_q[idx] + 8'sd1;
						end
						if (slot_calls_q[idx] != 16'hffff) begin
							slot_calls_q[idx] <= slot_calls_q[idx] + 16'd1;
						end
						slot_start_q[idx] <= ts_q;
					end
				end else begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
			nrp_pkg::ST_SCAN: begin
				if (in_range) begin
					if (slot_open_q[idx] > 8'sd0) begin
						count_q <= count_q + CW'(1);
						// latest start wins, later slot on a tie
						if (!parv_q || slot_start_q[idx] >= par_start_q) begin
							parv_q      <= 1'b1;
							par_q       <= idx;
							par_start_q <= slot_start_q[idx];
						end
					end
					cnt_q <= cnt_q + CW'(1);
				end
			end
			nrp_pkg::ST_UPD: begin
				slot_depth_q[hit_q] <= (count8 > 8'd31) ? 5'd31 : count8[4:0];
				slot_total_q[hit_q] <= (tot_sum > TOT_MAX) ? TOT_MAX[nrp_pkg::TOT_W-1:0]
				                                           : tot_sum[nrp_pkg::TOT_W-1:0];
				if (parv_q) begin
					slot_child_q[par_q] <= (chd_sum > TOT_MAX) ? TOT_MAX[nrp_pkg::TOT_W-1:0]
					                                           : chd_sum[nrp_pkg::TOT_W-1:0];
				end
			end
			nrp_pkg::ST_FMUL: begin
				prod_q <= mul_p;
				len_q  <= ts_q - frame_start_q;
			end
			nrp_pkg::ST_FRATIO: begin
				ratio_q <= (ratio_raw > 20'd65536) ? 17'd65536 : ratio_raw[16:0];
				cnt_q   <= '0;
			end
			nrp_pkg::ST_PREP: begin
				rg_q  <= slot_region_q[idx];
				neg_q <= neg;
				rem_q <= num;
				dsr_q <= RW'(len_q) << 17;
				k_q   <= 5'd17;
				quo_q <= '0;
				ovf_q <= 1'b0;
				sel_q <= nrp_pkg::SEL_AVG;
				if (mag == '0) begin
					p_q <= '0;
				end else if (len_q == '0) begin
					p_q <= neg ? 16'sh8000 : 16'sh7fff;
				end
			end
			nrp_pkg::ST_DIV: begin
				dsr_q <= dsr_q >> 1;
				if (k_q == 5'd17) begin
					ovf_q <= div_ge;
				end else begin
					if (div_ge) begin
						rem_q <= rem_q - dsr_q;
					end
					quo_q <= {quo_q[15:0], div_ge};
				end
				k_q <= k_q - 5'd1;
			end
			nrp_pkg::ST_PFIN: begin
				if (neg_q) begin
					p_q <= (ovf_q || quo_q >= 17'd32768) ? 16'sh8000 : 16'(17'd0 - quo_q);
				end else begin
					p_q <= (ovf_q || quo_q >= 17'd32767) ? 16'sh7fff : quo_q[15:0];
				end
			end
			nrp_pkg::ST_HIST: begin
				if (!hist_valid_q[rg_q]) begin
					hist_avg_q[rg_q] <= p_q;
					hist_min_q[rg_q] <= (p_q < 16'sd0) ? 16'sd0 : p_q;
					hist_max_q[rg_q] <= p_q;
				end
			end
			nrp_pkg::ST_BMUL: begin
				prod_q <= mul_p;
			end
			nrp_pkg::ST_BWR: begin
				unique case (sel_q)
					nrp_pkg::SEL_AVG: begin
						hist_avg_q[rg_q] <= bl;
						sel_q <= nrp_pkg::SEL_MIN;
					end
					nrp_pkg::SEL_MIN: begin
						hist_min_q[rg_q] <= (min_pick < 16'sd0) ? 16'sd0 : min_pick;
						sel_q <= nrp_pkg::SEL_MAX;
					end
					default: begin
						hist_max_q[rg_q] <= (p_q > h_cur) ? p_q : bl;
					end
				endcase
			end
			nrp_pkg::ST_EMIT: begin
				if (can_load) begin
					rsp_q.out_region    <= rg_q;
					rsp_q.avg_percent   <= hist_avg_q[rg_q];
					rsp_q.min_percent   <= hist_min_q[rg_q][14:0];
					rsp_q.max_percent   <= hist_max_q[rg_q];
					rsp_q.call_count    <= slot_calls_q[idx];
					rsp_q.nesting_depth <= slot_depth_q[idx];
					rsp_q.unbalanced    <= slot_open_q[idx] != 8'sd0;
					rsp_q.last_line     <= is_last;
					cnt_q               <= cnt_q + CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign req_ready = state_q == nrp_pkg::ST_IDLE;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== tb/nrp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrp_checker: profile predictor and report line scoreboard
// Watches the request, report and gain channels, models the slot table and
// region history, and compares every report line with the predicted one.
// ----------------------------------------------------------------------------
module nrp_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_ready,
	input  nrp_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_ready,
	input  nrp_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	input  logic          cfg_ready,
	input  logic [15:0]   cfg_data,
	output int            errors,
	output int            pending
);

	localparam int NSLOT = 16;
	localparam logic [39:0] TOT_MAX = 40'hff_ffff_ffff;

	logic [3:0]        tab_region[NSLOT];
	logic signed [7:0] tab_open[NSLOT];
	logic [15:0]       tab_calls[NSLOT];
	logic [31:0]       tab_start[NSLOT];
	logic [39:0]       tab_total[NSLOT];
	logic [39:0]       tab_child[NSLOT];
	logic [4:0]        tab_depth[NSLOT];
	int                tab_used;
	logic [31:0]       frame_t0;
	bit                seen[nrp_pkg::REGIONS];
	int                avg_h[nrp_pkg::REGIONS];
	int                min_h[nrp_pkg::REGIONS];
	int                max_h[nrp_pkg::REGIONS];
	logic [15:0]       gain;
	nrp_pkg::rsp_t     line_q[$];

	function automatic logic [39:0] add_sat(logic [39:0] a, logic [39:0] b);
		logic [40:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s > {1'b0, TOT_MAX} ? TOT_MAX : s[39:0];
	endfunction

	function automatic int self_percent(logic [39:0] tot, logic [39:0] child,
		logic [31:0] len);
		logic [63:0] mag;
		logic [63:0] q;
		bit neg;
		neg = child > tot;
		mag = neg ? 64'(child - tot) : 64'(tot - child);
		if (mag == 0) return 0;
		if (len == 0) return neg ? -32768 : 32767;
		q = (mag * 64'd25600 + 64'(len) / 2) / 64'(len);
		if (neg) return q >= 32768 ? -32768 : -int'(q);
		return q >= 32767 ? 32767 : int'(q);
	endfunction

	function automatic int smooth(int h, int p, logic [16:0] r);
		longint s;
		longint q;
		s = longint'(h) * (65536 - longint'(r)) + longint'(p) * longint'(r);
		q = (s + 32768) >>> 16;
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return int'(q);
	endfunction

	function automatic int find_region(logic [3:0] id);
		for (int i = 0; i < tab_used; i++)
			if (tab_region[i] == id) return i;
		return -1;
	endfunction

	task automatic predict(nrp_pkg::req_t rq);
		int s;
		int cnt;
		int par;
		logic [31:0] dur;
		logic [31:0] len;
		logic [35:0] prod;
		logic [16:0] r;
		int p;
		int m;
		logic [3:0] rg;
		nrp_pkg::rsp_t o;
		s = find_region(rq.region_id);
		case (rq.req_type)
			nrp_pkg::REQ_BEGIN: begin
				if (s < 0) begin
					if (tab_used < NSLOT) begin
						tab_region[tab_used] = rq.region_id;
						tab_open[tab_used] = 1;
						tab_calls[tab_used] = 1;
						tab_start[tab_used] = rq.timestamp;
						tab_total[tab_used] = 0;
						tab_child[tab_used] = 0;
						tab_depth[tab_used] = 0;
						tab_used++;
					end
				end else begin
					if (tab_open[s] < 127) tab_open[s]++;
					if (tab_calls[s] != 16'hffff) tab_calls[s]++;
					tab_start[s] = rq.timestamp;
				end
			end
			nrp_pkg::REQ_END: begin
				if (s >= 0) begin
					if (tab_open[s] > -128) tab_open[s]--;
					cnt = 0;
					par = -1;
					for (int i = 0; i < tab_used; i++) begin
						if (tab_open[i] > 0) begin
							cnt++;
							if (par < 0 || tab_start[i] >= tab_start[par]) par = i;
						end
					end
					tab_depth[s] = cnt > 31 ? 5'd31 : 5'(cnt);
					dur = rq.timestamp - tab_start[s];
					if (par >= 0) tab_child[par] = add_sat(tab_child[par], 40'(dur));
					tab_total[s] = add_sat(tab_total[s], 40'(dur));
				end
			end
			nrp_pkg::REQ_FRAME: begin
				len = rq.timestamp - frame_t0;
				prod = (36'(gain) * 36'(rq.elapsed_time)) >> 16;
				r = prod > 36'd65536 ? 17'd65536 : 17'(prod);
				for (int i = 0; i < tab_used; i++) begin
					rg = tab_region[i];
					p = self_percent(tab_total[i], tab_child[i], len);
					if (!seen[rg]) begin
						seen[rg] = 1;
						avg_h[rg] = p;
						min_h[rg] = p < 0 ? 0 : p;
						max_h[rg] = p;
					end else begin
						avg_h[rg] = smooth(avg_h[rg], p, r);
						m = p < min_h[rg] ? p : smooth(min_h[rg], p, r);
						min_h[rg] = m < 0 ? 0 : m;
						max_h[rg] = p > max_h[rg] ? p : smooth(max_h[rg], p, r);
					end
					o.out_region = rg;
					o.avg_percent = 16'(avg_h[rg]);
					o.min_percent = 15'(min_h[rg]);
					o.max_percent = 16'(max_h[rg]);
					o.call_count = tab_calls[i];
					o.nesting_depth = tab_depth[i];
					o.unbalanced = tab_open[i] != 0;
					o.last_line = i == tab_used - 1;
					line_q = {line_q, o};
				end
				tab_used = 0;
				frame_t0 = rq.timestamp;
			end
			default: ;
		endcase
	endtask

	task automatic cmp_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		nrp_pkg::rsp_t e;
		if (!arst_n) begin
			tab_used = 0;
			frame_t0 = 0;
			gain = nrp_pkg::GAIN_RESET;
			foreach (seen[i]) seen[i] = 0;
			line_q.delete();
			pending = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (line_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected report line, expected none, got %p", $time, rsp);
				end else begin
					e = line_q.pop_front();
					cmp_field("out_region", e.out_region, rsp.out_region);
					cmp_field("avg_percent", e.avg_percent, rsp.avg_percent);
					cmp_field("min_percent", e.min_percent, rsp.min_percent);
					cmp_field("max_percent", e.max_percent, rsp.max_percent);
					cmp_field("call_count", e.call_count, rsp.call_count);
					cmp_field("nesting_depth", e.nesting_depth, rsp.nesting_depth);
					cmp_field("unbalanced", e.unbalanced, rsp.unbalanced);
					cmp_field("last_line", e.last_line, rsp.last_line);
				end
			end
			if (cfg_valid && cfg_ready) gain = cfg_data;
			if (req_valid && req_ready) predict(req);
			pending = line_q.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: nested region profiler testbench
// Directed and random nested begin/end frames under several smoothing gains,
// random idling on both channels and a long report stall.
// ----------------------------------------------------------------------------
module tb;

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_ready;
	nrp_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_ready;
	nrp_pkg::rsp_t rsp;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [15:0]   cfg_data;
	int            errors;
	int            pending;

	bit          quiet;
	bit          stall_go;
	int          n_sent;
	logic [31:0] now_ts;

	nested_region_profiler_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	nrp_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	initial clk = 0;
	always #10 clk = ~clk;

	initial begin
		#20_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// report side: random back-pressure plus one long hold-off
	initial begin
		bit stall_seen;
		rsp_ready = 0;
		stall_seen = 0;
		forever begin
			@(negedge clk);
			if (stall_go && !stall_seen) begin
				stall_seen = 1;
				rsp_ready = 0;
				repeat (4000) @(negedge clk);
			end
			rsp_ready = quiet ? 1'b1 : ($urandom_range(99) >= 12);
		end
	end

	task automatic send(nrp_pkg::req_code_t kind, logic [3:0] id, logic [31:0] ts,
		logic [19:0] el);
		if (!quiet && $urandom_range(99) < 12) begin
			req_valid = 0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		req_valid = 1;
		req.req_type = kind;
		req.region_id = id;
		req.timestamp = ts;
		req.elapsed_time = el;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
		req_valid = 0;
		n_sent++;
	endtask

	task automatic write_gain(logic [15:0] g);
		while (pending != 0) @(negedge clk);
		repeat (80) @(negedge clk);
		cfg_valid = 1;
		cfg_data = g;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	function automatic logic [19:0] pick_elapsed();
		case ($urandom_range(5))
			0: return 20'd0;
			1: return 20'hfffff;
			default: return 20'($urandom_range(20'hfffff));
		endcase
	endfunction

	function automatic logic [31:0] step_ts();
		case ($urandom_range(19))
			0: return 0;
			1: return $urandom;
			default: return $urandom_range(1, 3000);
		endcase
	endfunction

	// one frame of nested begin/end pairs, with occasional noise
	task automatic random_frame(int nreg);
		logic [3:0] ids[$];
		logic [3:0] stk[$];
		logic [3:0] id;
		int steps;
		for (int i = 0; i < 16; i++) ids = {ids, 4'(i)};
		ids.shuffle();
		while (ids.size() > nreg) void'(ids.pop_back());
		steps = $urandom_range(2, 4 * nreg + 2);
		for (int k = 0; k < steps; k++) begin
			now_ts += step_ts();
			case ($urandom_range(19))
				0: send(nrp_pkg::REQ_NONE, 4'($urandom), $urandom, 20'($urandom));
				1: send(nrp_pkg::REQ_END, 4'($urandom), now_ts, 20'($urandom));
				2: send(nrp_pkg::REQ_BEGIN, 4'($urandom), now_ts, 20'($urandom));
				default: begin
					if (stk.size() == 0 || (stk.size() < 6 && $urandom_range(1))) begin
						id = ids[$urandom_range(ids.size() - 1)];
						stk = {stk, id};
						send(nrp_pkg::REQ_BEGIN, id, now_ts, 20'($urandom));
					end else begin
						send(nrp_pkg::REQ_END, stk.pop_back(), now_ts, 20'($urandom));
					end
				end
			endcase
		end
		if ($urandom_range(3) != 0)
			while (stk.size() > 0) begin
				now_ts += step_ts();
				send(nrp_pkg::REQ_END, stk.pop_back(), now_ts, 20'($urandom));
			end
		now_ts += step_ts();
		send(nrp_pkg::REQ_FRAME, 4'($urandom), now_ts, pick_elapsed());
	endtask

	initial begin
		logic [15:0] gains[4];
		req_valid = 0;
		req = '0;
		cfg_valid = 0;
		cfg_data = 0;
		quiet = 0;
		stall_go = 0;
		n_sent = 0;
		now_ts = 0;
		arst_n = 0;
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: nesting, negative self time, wrap, empty and zero-length frames
		send(nrp_pkg::REQ_BEGIN, 4'd0, 32'd0, 20'd0);
		send(nrp_pkg::REQ_BEGIN, 4'd15, 32'd100, 20'd0);
		send(nrp_pkg::REQ_END, 4'd15, 32'd300, 20'd0);
		send(nrp_pkg::REQ_END, 4'd0, 32'd1000, 20'd0);
		send(nrp_pkg::REQ_FRAME, 4'd0, 32'd1000, 20'd0);
		send(nrp_pkg::REQ_FRAME, 4'd0, 32'd2000, 20'hfffff);
		send(nrp_pkg::REQ_BEGIN, 4'd1, 32'd2000, 20'd0);
		send(nrp_pkg::REQ_BEGIN, 4'd2, 32'd2050, 20'd0);
		send(nrp_pkg::REQ_END, 4'd1, 32'd2200, 20'd0);
		send(nrp_pkg::REQ_END, 4'd2, 32'd2210, 20'd0);
		send(nrp_pkg::REQ_END, 4'd9, 32'd2220, 20'd0);
		send(nrp_pkg::REQ_NONE, 4'd15, 32'hffff_ffff, 20'hfffff);
		send(nrp_pkg::REQ_FRAME, 4'd15, 32'd2300, 20'h10000);
		send(nrp_pkg::REQ_BEGIN, 4'd0, 32'd2300, 20'd0);
		send(nrp_pkg::REQ_FRAME, 4'd0, 32'd2300, 20'h8000);
		send(nrp_pkg::REQ_BEGIN, 4'd15, 32'hffff_fff0, 20'd0);
		send(nrp_pkg::REQ_END, 4'd15, 32'h10, 20'd0);
		send(nrp_pkg::REQ_END, 4'd15, 32'h20, 20'd0);
		send(nrp_pkg::REQ_FRAME, 4'd0, 32'h30, 20'hfffff);
		now_ts = 32'h30;

		// deep open count: saturates the signed counter
		for (int i = 0; i < 130; i++) send(nrp_pkg::REQ_BEGIN, 4'd7, now_ts + i, 20'd0);
		now_ts += 200;
		send(nrp_pkg::REQ_END, 4'd7, now_ts, 20'd0);
		send(nrp_pkg::REQ_FRAME, 4'd0, now_ts + 10, 20'd5);
		now_ts += 10;

		gains[0] = nrp_pkg::GAIN_RESET;
		gains[1] = 16'd0;
		gains[2] = 16'hffff;
		gains[3] = 16'($urandom);
		for (int ph = 0; ph < 4; ph++) begin
			write_gain(gains[ph]);
			quiet = ph == 2;
			while (n_sent < 150 + 75 * (ph + 1)) begin
				if (ph == 1 && !stall_go) begin
					stall_go = 1;
					random_frame(16);
				end else begin
					random_frame($urandom_range(7) == 0 ? 16 : $urandom_range(1, 5));
				end
			end
		end
		quiet = 0;

		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
